[design/cosine_hemisphere_sample_core_assert.svh]
// Assertion macros for the cosine hemisphere sample core.
// Included by modules that check their own pipeline control.
`ifndef COSINE_HEMISPHERE_SAMPLE_CORE_ASSERT_SVH
`define COSINE_HEMISPHERE_SAMPLE_CORE_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define CHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chs: next-cycle check failed");

// consequent must hold in the same cycle as the antecedent
`define CHS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chs: same-cycle check failed");

`endif

[design/chs_pkg.sv]
// Shared types, constants and the arctangent table of the cosine hemisphere sample core.
// No dependencies.
package chs_pkg;

   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int OUT_FRAC_BITS_DEF = 14;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int QF         = 30;       // internal fraction bits
   localparam int DIV_STEPS  = QF + 1;   // quotient bits of the minor/dominant ratio
   localparam int CW         = 33;       // signed CORDIC word
   localparam int SQ_W       = 64;       // root datapath width
   localparam int SQRT_STEPS = 32;

   localparam logic [QF-1:0] PI4_Q30  = 30'd843314857;   // pi/4
   localparam logic [QF-1:0] GAIN_Q30 = 30'd652032874;   // 1/K of CORDIC

   typedef enum logic [1:0] {
      QUAD_E = 2'd0,
      QUAD_N = 2'd1,
      QUAD_W = 2'd2,
      QUAD_S = 2'd3
   } quad_type;

   typedef struct packed {
      quad_type quad;
      logic     origin;
   } turn_side_type;

   typedef struct packed {
      logic signed [CW-1:0] tx;
      logic signed [CW-1:0] ty;
      logic                 origin;
   } lift_side_type;

   function automatic logic [QF-1:0] atan_q30(input int idx);
      logic [QF-1:0] a;
      unique case (idx)
         0:  a = 30'h3243F6A8;
         1:  a = 30'h1DAC6705;
         2:  a = 30'h0FADBAFC;
         3:  a = 30'h07F56EA6;
         4:  a = 30'h03FEAB76;
         5:  a = 30'h01FFD55B;
         6:  a = 30'h00FFFAAA;
         7:  a = 30'h007FFF55;
         8:  a = 30'h003FFFEA;
         9:  a = 30'h001FFFFD;
         10: a = 30'h000FFFFF;
         11: a = 30'h0007FFFF;
         12: a = 30'h0003FFFF;
         13: a = 30'h0001FFFF;
         14: a = 30'h0000FFFF;
         15: a = 30'h00007FFF;
         16: a = 30'h00003FFF;
         17: a = 30'h00001FFF;
         18: a = 30'h00000FFF;
         19: a = 30'h000007FF;
         20: a = 30'h000003FF;
         21: a = 30'h000001FF;
         22: a = 30'h000000FF;
         23: a = 30'h0000007F;
         24: a = 30'h0000003F;
         25: a = 30'h0000001F;
         26: a = 30'h0000000F;
         27: a = 30'h00000007;
         28: a = 30'h00000003;
         29: a = 30'h00000001;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

[design/chs_if.sv]
// Request and response stream interfaces of the cosine hemisphere sample core.
// Depends on chs_pkg for default widths.
interface chs_req_if #(parameter int SAMPLE_BITS = chs_pkg::SAMPLE_BITS_DEF);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] first_uniform;
   logic [SAMPLE_BITS-1:0] second_uniform;
   modport source(output valid, output first_uniform, output second_uniform, input ready);
   modport sink(input valid, input first_uniform, input second_uniform, output ready);
endinterface

interface chs_rsp_if #(parameter int OUT_FRAC_BITS = chs_pkg::OUT_FRAC_BITS_DEF);
   logic                            valid;
   logic                            ready;
   logic signed [OUT_FRAC_BITS+1:0] dir_x;
   logic signed [OUT_FRAC_BITS+1:0] dir_y;
   logic        [OUT_FRAC_BITS:0]   dir_z;
   modport source(output valid, output dir_x, output dir_y, output dir_z, input ready);
   modport sink(input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

[design/chs_cordic.sv]
// Pipelined rotation-mode CORDIC, one register stage per iteration.
// Depends on chs_pkg (word width, arctangent table, side-band type).
module chs_cordic #(
   parameter int STAGES = chs_pkg::CORDIC_STAGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  logic signed [chs_pkg::CW-1:0]   in_x,
   input  logic signed [chs_pkg::CW-1:0]   in_z,
   input  chs_pkg::turn_side_type          in_side,
   output logic                            out_valid,
   output logic signed [chs_pkg::CW-1:0]   out_x,
   output logic signed [chs_pkg::CW-1:0]   out_y,
   output chs_pkg::turn_side_type          out_side
);
   import chs_pkg::*;

   logic                 cr_valid_ff [1:STAGES];
   logic signed [CW-1:0] cr_x_ff     [1:STAGES];
   logic signed [CW-1:0] cr_y_ff     [1:STAGES];
   logic signed [CW-1:0] cr_z_ff     [1:STAGES];
   turn_side_type        cr_side_ff  [1:STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic                 vi;
      logic signed [CW-1:0] xi;
      logic signed [CW-1:0] yi;
      logic signed [CW-1:0] zi;
      turn_side_type        si;
      logic signed [CW-1:0] ang;

      if (i == 0) begin : g_head
         assign vi = in_valid;
         assign xi = in_x;
         assign yi = '0;
         assign zi = in_z;
         assign si = in_side;
      end else begin : g_body
         assign vi = cr_valid_ff[i];
         assign xi = cr_x_ff[i];
         assign yi = cr_y_ff[i];
         assign zi = cr_z_ff[i];
         assign si = cr_side_ff[i];
      end

      assign ang = $signed({{(CW-QF){1'b0}}, atan_q30(i)});

      always_ff @(posedge clock) begin
         if (reset) begin
            cr_valid_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cr_valid_ff[i+1] <= vi;
         end
         if (adv) begin
            cr_side_ff[i+1] <= si;
            // nonnegative residual turns the positive way
            if (!zi[CW-1]) begin
               cr_x_ff[i+1] <= xi - (yi >>> i);
               cr_y_ff[i+1] <= yi + (xi >>> i);
               cr_z_ff[i+1] <= zi - ang;
            end else begin
               cr_x_ff[i+1] <= xi + (yi >>> i);
               cr_y_ff[i+1] <= yi - (xi >>> i);
               cr_z_ff[i+1] <= zi + ang;
            end
         end
      end
   end

   assign out_valid = cr_valid_ff[STAGES];
   assign out_x     = cr_x_ff[STAGES];
   assign out_y     = cr_y_ff[STAGES];
   assign out_side  = cr_side_ff[STAGES];

endmodule

[design/chs_sqrt.sv]
// Pipelined bitwise integer square root, one result bit per register stage.
// Depends on chs_pkg (root width, step count, side-band type).
module chs_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [chs_pkg::SQ_W-1:0]     in_rem,
   input  chs_pkg::lift_side_type       in_side,
   output logic                         out_valid,
   output logic [chs_pkg::SQ_W-1:0]     out_root,
   output chs_pkg::lift_side_type       out_side
);
   import chs_pkg::*;

   logic            sr_valid_ff [1:SQRT_STEPS];
   logic [SQ_W-1:0] sr_v_ff     [1:SQRT_STEPS];
   logic [SQ_W-1:0] sr_res_ff   [1:SQRT_STEPS];
   lift_side_type   sr_side_ff  [1:SQRT_STEPS];

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * i);
      logic            vi;
      logic [SQ_W-1:0] v_i;
      logic [SQ_W-1:0] res_i;
      lift_side_type   si;
      logic [SQ_W-1:0] trial;

      if (i == 0) begin : g_head
         assign vi    = in_valid;
         assign v_i   = in_rem;
         assign res_i = '0;
         assign si    = in_side;
      end else begin : g_body
         assign vi    = sr_valid_ff[i];
         assign v_i   = sr_v_ff[i];
         assign res_i = sr_res_ff[i];
         assign si    = sr_side_ff[i];
      end

      assign trial = res_i + BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            sr_valid_ff[i+1] <= 1'b0;
         end else if (adv) begin
            sr_valid_ff[i+1] <= vi;
         end
         if (adv) begin
            sr_side_ff[i+1] <= si;
            if (v_i >= trial) begin
               sr_v_ff[i+1]   <= v_i - trial;
               sr_res_ff[i+1] <= (res_i >> 1) + BIT;
            end else begin
               sr_v_ff[i+1]   <= v_i;
               sr_res_ff[i+1] <= res_i >> 1;
            end
         end
      end
   end

   assign out_valid = sr_valid_ff[SQRT_STEPS];
   assign out_root  = sr_res_ff[SQRT_STEPS];
   assign out_side  = sr_side_ff[SQRT_STEPS];

endmodule

[design/cosine_hemisphere_sample_core.sv]
// Top level of the cosine hemisphere sample core: concentric disk mapping and lift.
// Depends on chs_pkg, chs_if, chs_cordic, chs_sqrt and the assertion header.
//
// Turns a pair of uniform Q0.SAMPLE_BITS numbers into a cosine-weighted unit
// direction (dir_x, dir_y signed Q1.OUT_FRAC_BITS, dir_z unsigned), via the
// concentric square-to-disk map. Fully pipelined: one transaction in and one
// out per cycle while results are taken. Its stages: one front stage,
// 31 restoring-divider stages for the minor/dominant ratio, one multiply
// stage, CORDIC_STAGES rotation stages, quadrant, square and remainder
// stages, 32 square-root stages and the output register. The whole
// pipeline holds while a finished result is not taken; nothing is dropped.
`include "cosine_hemisphere_sample_core_assert.svh"

module cosine_hemisphere_sample_core #(
   parameter int SAMPLE_BITS   = chs_pkg::SAMPLE_BITS_DEF,
   parameter int OUT_FRAC_BITS = chs_pkg::OUT_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = chs_pkg::CORDIC_STAGES_DEF
) (
   input logic       clock,
   input logic       reset,
   chs_req_if.sink   req_chan,
   chs_rsp_if.source rsp_chan
);
   import chs_pkg::*;

   localparam int     S     = SAMPLE_BITS;
   localparam int     F     = OUT_FRAC_BITS;
   localparam int     SH    = QF - F;
   localparam int     XYW   = F + 2;
   localparam int     ZW    = F + 1;
   localparam int     XW    = CW + 1;
   localparam int     RQ_W  = S + 1 + QF;
   localparam longint RND   = (longint'(1) << SH) >> 1;
   localparam longint ONE_L = longint'(1) << F;

   logic adv;
   logic rsp_valid_ff;

   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // ---------------- front: wedge choice ----------------
   logic signed [S+1:0] sx, sy, r_s, minor_s, minor_mag;
   quad_type            quad;

   always_comb begin
      sx = $signed({1'b0, req_chan.first_uniform, 1'b0}) - $signed({2'b01, {S{1'b0}}});
      sy = $signed({1'b0, req_chan.second_uniform, 1'b0}) - $signed({2'b01, {S{1'b0}}});
      if (sx >= -sy) begin
         if (sx > sy) begin
            r_s = sx;  minor_s = sy;  quad = QUAD_E;
         end else begin
            r_s = sy;  minor_s = -sx; quad = QUAD_N;
         end
      end else begin
         if (sx <= sy) begin
            r_s = -sx; minor_s = -sy; quad = QUAD_W;
         end else begin
            r_s = -sy; minor_s = sx;  quad = QUAD_S;
         end
      end
      minor_mag = minor_s[S+1] ? -minor_s : minor_s;
   end

   // ---------------- restoring divider ----------------
   logic          dv_valid_ff [0:DIV_STEPS];
   logic [S:0]    dv_rem_ff   [0:DIV_STEPS];
   logic [S:0]    dv_r_ff     [0:DIV_STEPS];
   logic [QF:0]   dv_quo_ff   [0:DIV_STEPS];
   logic          dv_neg_ff   [0:DIV_STEPS];
   turn_side_type dv_side_ff  [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_valid_ff[0] <= req_chan.valid;
      end
      if (adv) begin
         dv_rem_ff[0]         <= minor_mag[S:0];
         dv_r_ff[0]           <= r_s[S:0];
         dv_quo_ff[0]         <= '0;
         dv_neg_ff[0]         <= minor_s[S+1];
         dv_side_ff[0].quad   <= quad;
         dv_side_ff[0].origin <= (sx == '0) && (sy == '0);
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [S+1:0] trial;
      logic [S+1:0] diff;
      logic         take;

      always_comb begin
         // first step: numerator never exceeds divisor, so no shift
         if (j == 0) begin
            trial = {1'b0, dv_rem_ff[j]};
         end else begin
            trial = {dv_rem_ff[j], 1'b0};
         end
         take = trial >= {1'b0, dv_r_ff[j]};
         diff = trial - {1'b0, dv_r_ff[j]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
         if (adv) begin
            dv_rem_ff[j+1]  <= take ? diff[S:0] : trial[S:0];
            dv_quo_ff[j+1]  <= {dv_quo_ff[j][QF-1:0], take};
            dv_r_ff[j+1]    <= dv_r_ff[j];
            dv_neg_ff[j+1]  <= dv_neg_ff[j];
            dv_side_ff[j+1] <= dv_side_ff[j];
         end
      end
   end

   // ---------------- angle and start vector ----------------
   logic [2*QF:0]        prod_d, prod_x;
   logic [RQ_W-1:0]      rq_wide;
   logic [QF:0]          rq;
   logic signed [CW-1:0] d_ext, x_ext;
   logic                 m_valid_ff;
   logic signed [CW-1:0] m_x0_ff, m_z0_ff;
   turn_side_type        m_side_ff;

   always_comb begin
      prod_d  = dv_quo_ff[DIV_STEPS] * PI4_Q30;
      rq_wide = {dv_r_ff[DIV_STEPS], {QF{1'b0}}} >> S;
      rq      = rq_wide[QF:0];
      prod_x  = rq * GAIN_Q30;
      d_ext   = $signed({{(CW-QF-1){1'b0}}, prod_d[2*QF:QF]});
      x_ext   = $signed({{(CW-QF-1){1'b0}}, prod_x[2*QF:QF]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= dv_valid_ff[DIV_STEPS];
      end
      if (adv) begin
         m_x0_ff   <= x_ext;
         m_z0_ff   <= dv_neg_ff[DIV_STEPS] ? -d_ext : d_ext;
         m_side_ff <= dv_side_ff[DIV_STEPS];
      end
   end

   // ---------------- CORDIC ----------------
   logic                 cr_valid;
   logic signed [CW-1:0] cr_x, cr_y;
   turn_side_type        cr_side;

   chs_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (m_valid_ff),
      .in_x      (m_x0_ff),
      .in_z      (m_z0_ff),
      .in_side   (m_side_ff),
      .out_valid (cr_valid),
      .out_x     (cr_x),
      .out_y     (cr_y),
      .out_side  (cr_side)
   );

   // ---------------- quadrant turn ----------------
   logic                 q_valid_ff, q_origin_ff;
   logic signed [CW-1:0] q_tx_ff, q_ty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else if (adv) begin
         q_valid_ff <= cr_valid;
      end
      if (adv) begin
         q_origin_ff <= cr_side.origin;
         unique case (cr_side.quad)
            QUAD_E: begin q_tx_ff <= cr_x;  q_ty_ff <= cr_y;  end
            QUAD_N: begin q_tx_ff <= -cr_y; q_ty_ff <= cr_x;  end
            QUAD_W: begin q_tx_ff <= -cr_x; q_ty_ff <= -cr_y; end
            QUAD_S: begin q_tx_ff <= cr_y;  q_ty_ff <= -cr_x; end
            default: begin q_tx_ff <= cr_x; q_ty_ff <= cr_y;  end
         endcase
      end
   end

   // ---------------- squares ----------------
   logic signed [CW-1:0] abs_x, abs_y;
   logic                 p_valid_ff;
   logic [SQ_W-1:0]      p_sqx_ff, p_sqy_ff;
   lift_side_type        p_side_ff;

   assign abs_x = q_tx_ff[CW-1] ? -q_tx_ff : q_tx_ff;
   assign abs_y = q_ty_ff[CW-1] ? -q_ty_ff : q_ty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= q_valid_ff;
      end
      if (adv) begin
         p_sqx_ff         <= abs_x[31:0] * abs_x[31:0];
         p_sqy_ff         <= abs_y[31:0] * abs_y[31:0];
         p_side_ff.tx     <= q_tx_ff;
         p_side_ff.ty     <= q_ty_ff;
         p_side_ff.origin <= q_origin_ff;
      end
   end

   // ---------------- remainder 1 - r^2 ----------------
   logic [SQ_W:0]   sq_sum;
   logic            rm_valid_ff;
   logic [SQ_W-1:0] rm_rem_ff;
   lift_side_type   rm_side_ff;
   localparam logic [SQ_W:0] ONE_SQ = (SQ_W+1)'(1) << (2 * QF);

   assign sq_sum = {1'b0, p_sqx_ff} + {1'b0, p_sqy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rm_valid_ff <= 1'b0;
      end else if (adv) begin
         rm_valid_ff <= p_valid_ff;
      end
      if (adv) begin
         rm_side_ff <= p_side_ff;
         if (sq_sum >= ONE_SQ) begin
            rm_rem_ff <= '0;
         end else begin
            rm_rem_ff <= SQ_W'(ONE_SQ - sq_sum);
         end
      end
   end

   // ---------------- square root ----------------
   logic            sq_valid;
   logic [SQ_W-1:0] sq_root;
   lift_side_type   sq_side;

   chs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (rm_valid_ff),
      .in_rem    (rm_rem_ff),
      .in_side   (rm_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ---------------- rounding, clamp, output register ----------------
   logic signed [XW-1:0] ox, oy, cx, cy;
   logic [SQ_W-1:0]      oz, cz;
   logic signed [XYW-1:0] rsp_x_ff;
   logic signed [XYW-1:0] rsp_y_ff;
   logic [ZW-1:0]         rsp_z_ff;

   always_comb begin
      ox = ($signed({sq_side.tx[CW-1], sq_side.tx}) + XW'(RND)) >>> SH;
      oy = ($signed({sq_side.ty[CW-1], sq_side.ty}) + XW'(RND)) >>> SH;
      oz = (sq_root + SQ_W'(RND)) >> SH;
      cx = ox;
      if (ox > XW'(ONE_L)) cx = XW'(ONE_L);
      if (ox < XW'(-ONE_L)) cx = XW'(-ONE_L);
      cy = oy;
      if (oy > XW'(ONE_L)) cy = XW'(ONE_L);
      if (oy < XW'(-ONE_L)) cy = XW'(-ONE_L);
      cz = (oz > SQ_W'(ONE_L)) ? SQ_W'(ONE_L) : oz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sq_valid;
      end
      if (adv) begin
         // center of the square maps straight up
         if (sq_side.origin) begin
            rsp_x_ff <= '0;
            rsp_y_ff <= '0;
            rsp_z_ff <= ZW'(ONE_L);
         end else begin
            rsp_x_ff <= cx[XYW-1:0];
            rsp_y_ff <= cy[XYW-1:0];
            rsp_z_ff <= cz[ZW-1:0];
         end
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.dir_x = rsp_x_ff;
   assign rsp_chan.dir_y = rsp_y_ff;
   assign rsp_chan.dir_z = rsp_z_ff;

   // ---------------- checks ----------------
   `CHS_ASSERT_NEXT(a_div_moves, clock, reset, adv && dv_valid_ff[0], dv_valid_ff[1])
   `CHS_ASSERT_NEXT(a_stall_holds_root, clock, reset, !adv, $stable(sq_valid) && $stable(sq_root))
   `CHS_ASSERT_NOW(a_height_range, clock, reset, rsp_valid_ff, rsp_z_ff <= ZW'(ONE_L))

endmodule
